/* sv/hfr1_pkg.sv */
// Package: binary16 multiply, add and rounding helpers for the rank-1 update core.
package hfr1_pkg;

   localparam logic [15:0] QNAN_BITS  = 16'h7E00;
   localparam logic [14:0] INF_MAG    = 15'h7C00;
   localparam logic [15:0] ALPHA_INIT = 16'h0000;

   // Count leading zeros of a 24-bit word (zero input not used).
   function automatic logic [4:0] hfr1_lzc(input logic [23:0] w);
      logic [4:0] n;
      logic       found;
      n     = 5'd0;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && w[i]) begin
            n     = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Round a normalised 24-bit significand to binary16, nearest even.
   function automatic logic [15:0] hfr1_round(input logic sign, input logic signed [7:0] be,
                                              input logic [23:0] mn);
      logic [7:0]  sh;
      logic [4:0]  ebase;
      logic [23:0] t;
      logic        lost;
      logic [10:0] q;
      logic        g;
      logic        st;
      logic        rnd;
      logic [15:0] res;
      if (be >= 8'sd31) begin
         res = {sign, INF_MAG};
      end else begin
         if (be >= 8'sd1) begin
            sh    = 8'd0;
            ebase = 5'(be - 8'sd1);
         end else begin
            sh    = 8'(8'sd1 - be);
            ebase = 5'd0;
         end
         if (sh >= 8'd24) begin
            t    = 24'd0;
            lost = |mn;
         end else begin
            t    = mn >> sh;
            lost = |(mn & ~(24'hFFFFFF << sh));
         end
         q   = t[23:13];
         g   = t[12];
         st  = (|t[11:0]) | lost;
         rnd = g & (st | q[0]);
         res = {sign, 15'({ebase, 10'b0}) + 15'(q) + 15'(rnd)};
      end
      return res;
   endfunction

   function automatic logic [15:0] hfr1_mul(input logic [15:0] a, input logic [15:0] b);
      logic              sgn;
      logic [4:0]        ea;
      logic [4:0]        eb;
      logic [10:0]       sa;
      logic [10:0]       sb;
      logic [21:0]       p;
      logic [23:0]       m0;
      logic [4:0]        lz;
      logic signed [7:0] be;
      logic              a_nan;
      logic              b_nan;
      logic              a_inf;
      logic              b_inf;
      logic              a_zero;
      logic              b_zero;
      logic [15:0]       res;
      sgn    = a[15] ^ b[15];
      a_nan  = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
      b_nan  = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
      a_inf  = (a[14:0] == INF_MAG);
      b_inf  = (b[14:0] == INF_MAG);
      a_zero = (a[14:0] == 15'd0);
      b_zero = (b[14:0] == 15'd0);
      ea     = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
      eb     = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
      sa     = {a[14:10] != 5'd0, a[9:0]};
      sb     = {b[14:10] != 5'd0, b[9:0]};
      p      = 22'(sa) * 22'(sb);
      m0     = {p, 2'b00};
      lz     = hfr1_lzc(m0);
      be     = signed'(8'(ea) + 8'(eb) - 8'd14 - 8'(lz));
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         res = QNAN_BITS;
      end else if (a_inf || b_inf) begin
         res = {sgn, INF_MAG};
      end else if (a_zero || b_zero) begin
         res = {sgn, 15'd0};
      end else begin
         res = hfr1_round(sgn, be, m0 << lz);
      end
      return res;
   endfunction

   function automatic logic [15:0] hfr1_add(input logic [15:0] a, input logic [15:0] b);
      logic [15:0]       l;
      logic [15:0]       s;
      logic [4:0]        el;
      logic [4:0]        es;
      logic [4:0]        d;
      logic [13:0]       lw;
      logic [13:0]       sw;
      logic [13:0]       sm;
      logic [14:0]       sum;
      logic [23:0]       m0;
      logic [4:0]        lz;
      logic signed [7:0] be;
      logic              a_nan;
      logic              b_nan;
      logic              a_inf;
      logic              b_inf;
      logic [15:0]       res;
      a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
      b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
      a_inf = (a[14:0] == INF_MAG);
      b_inf = (b[14:0] == INF_MAG);
      if (a[14:0] >= b[14:0]) begin
         l = a;
         s = b;
      end else begin
         l = b;
         s = a;
      end
      el = (l[14:10] == 5'd0) ? 5'd1 : l[14:10];
      es = (s[14:10] == 5'd0) ? 5'd1 : s[14:10];
      d  = el - es;
      lw = {l[14:10] != 5'd0, l[9:0], 3'b000};
      sw = {s[14:10] != 5'd0, s[9:0], 3'b000};
      if (d >= 5'd14) begin
         sm = {13'd0, |sw};
      end else begin
         sm    = sw >> d;
         sm[0] = sm[0] | (|(sw & ~(14'h3FFF << d)));
      end
      sum = (l[15] == s[15]) ? (15'(lw) + 15'(sm)) : (15'(lw) - 15'(sm));
      m0  = {sum, 9'd0};
      lz  = hfr1_lzc(m0);
      be  = signed'(8'(el) + 8'd1 - 8'(lz));
      if (a_nan || b_nan || (a_inf && b_inf && (a[15] != b[15]))) begin
         res = QNAN_BITS;
      end else if (a_inf) begin
         res = a;
      end else if (b_inf) begin
         res = b;
      end else if ((a[14:0] == 15'd0) && (b[14:0] == 15'd0)) begin
         res = {a[15] & b[15], 15'd0};
      end else if (sum == 15'd0) begin
         res = 16'd0;
      end else begin
         res = hfr1_round(l[15], be, m0 << lz);
      end
      return res;
   endfunction

endpackage

/* sv/half_float_rank1_update_core.sv */
// Top level: three-stage binary16 rank-1 element update a + x*(alpha*y).
// An accepted request beat moves through the stage 1, 2 and 3 registers; stage 3 drives its response beat.
// Throughput: one beat per cycle while the output is not stalled; stages are alpha*y, x*t, a+p, one each.
// A stalled output holds the last stage and every full stage before it; empty stages upstream still fill.
// Reset (synchronous, active high) empties the pipeline and clears alpha to +0.
module half_float_rank1_update_core
   import hfr1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_a_value,
   input  logic [15:0] req_x_value,
   input  logic [15:0] req_y_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_a_updated,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_alpha
);

   logic [15:0] alpha_ff;

   // stage 1: scale t = alpha*y
   logic        v1_ff;
   logic [15:0] a1_ff, x1_ff, t1_ff;
   logic        last1_ff, byp1_ff;
   // stage 2: product p = x*t
   logic        v2_ff;
   logic [15:0] a2_ff, p2_ff;
   logic        last2_ff, byp2_ff;
   // stage 3: sum, the output register
   logic        v3_ff;
   logic [15:0] r3_ff;
   logic        last3_ff;

   logic adv1, adv2, adv3;
   logic [15:0] t1_in, p2_in, r3_in;
   logic        byp1_in;

   // A stage advances when it is empty or the one after it moves on.
   assign adv3      = !v3_ff || !rsp_stall;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign csr_ready = 1'b1;

   // Zero alpha or zero y (either sign) passes the element through untouched.
   assign byp1_in = (alpha_ff[14:0] == 15'd0) || (req_y_value[14:0] == 15'd0);
   assign t1_in   = hfr1_mul(alpha_ff, req_y_value);
   assign p2_in   = hfr1_mul(x1_ff, t1_ff);
   assign r3_in   = byp2_ff ? a2_ff : hfr1_add(a2_ff, p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_INIT;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            alpha_ff <= csr_alpha;
         end
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Payload registers: load on advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (adv1) begin
         a1_ff    <= req_a_value;
         x1_ff    <= req_x_value;
         t1_ff    <= t1_in;
         last1_ff <= req_last_element;
         byp1_ff  <= byp1_in;
      end
      if (adv2) begin
         a2_ff    <= a1_ff;
         p2_ff    <= p2_in;
         last2_ff <= last1_ff;
         byp2_ff  <= byp1_ff;
      end
      if (adv3) begin
         r3_ff    <= r3_in;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_a_updated   = r3_ff;
   assign rsp_last_result = last3_ff;

`ifndef SYNTHESIS
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff))
      else $error("request stalled with an empty stage");
   a_hold_mid : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !adv3) |=> v2_ff)
      else $error("stage 2 beat dropped under stall");
   a_bypass : assert property (@(posedge clock) disable iff (reset)
      (adv3 && v2_ff && byp2_ff) |=> (rsp_a_updated == $past(a2_ff)))
      else $error("bypass element altered");
`endif

endmodule

/* tb/tb.sv */
// Testbench for half_float_rank1_update_core: random and directed binary16 rank-1 beats.
`timescale 1ns / 1ps

// Scoreboard: predicts a + x*(alpha*y) in binary16 and holds the updates still due.
class rank1_scoreboard;
   typedef struct {
      logic [15:0] a_updated;
      logic        last_result;
   } update_type;

   logic [15:0] alpha;
   update_type  due_q[$];
   int          mismatches;

   function new();
      alpha      = hfr1_pkg::ALPHA_INIT;
      mismatches = 0;
   endfunction

   // Widen a binary16 pattern to an exact real.
   function real half_to_real(logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      real         mag;
      ex  = h[14:10];
      man = h[9:0];
      if (ex == 5'h1F) begin
         return $bitstoreal({h[15], 11'h7FF, man != 10'd0, man[8:0], 42'd0});
      end
      if (ex == 5'd0) begin
         mag = real'(man) / 16777216.0;
      end else begin
         mag = real'(11'h400 | man) *
               $bitstoreal({1'b0, 11'(int'(ex) - 25 + 1023), 52'd0});
      end
      return h[15] ? -mag : mag;
   endfunction

   // Round a real to binary16, nearest even, gradual underflow.
   function logic [15:0] real_to_half(real d);
      logic [63:0] bits;
      logic        sgn;
      int          e;
      int          sh;
      logic [63:0] sig;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] halfway;
      bits = $realtobits(d);
      sgn  = bits[63];
      if (bits[62:52] == 11'h7FF) begin
         return (bits[51:0] != 0) ? hfr1_pkg::QNAN_BITS : {sgn, hfr1_pkg::INF_MAG};
      end
      if (bits[62:52] == 11'd0) return {sgn, 15'd0};
      e = int'(bits[62:52]) - 1023;
      if (e >= 16) return {sgn, hfr1_pkg::INF_MAG};
      sig = 64'({1'b1, bits[51:0]});
      if (e >= -14) begin
         sh = 42;
      end else begin
         if (-14 - e > 18) return {sgn, 15'd0};
         sh = 42 + (-14 - e);
      end
      q       = sig >> sh;
      rem     = sig & ((64'd1 << sh) - 64'd1);
      halfway = 64'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) q = q + 64'd1;
      if (e >= -14) return {sgn, 15'((e + 14) << 10) + 15'(q)};
      return {sgn, 15'(q)};
   endfunction

   function void note_request(logic [15:0] a, logic [15:0] x, logic [15:0] y,
                              logic last);
      update_type  u;
      logic [15:0] scaled;
      logic [15:0] prod;
      u.a_updated   = a;
      u.last_result = last;
      if (alpha[14:0] != 15'd0 && y[14:0] != 15'd0) begin
         scaled      = real_to_half(half_to_real(alpha) * half_to_real(y));
         prod        = real_to_half(half_to_real(x) * half_to_real(scaled));
         u.a_updated = real_to_half(half_to_real(a) + half_to_real(prod));
      end
      due_q.push_back(u);
   endfunction

   function void check_response(logic [15:0] a_upd, logic last);
      update_type u;
      if (due_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response beat: a_updated=%h last=%b", a_upd, last);
         return;
      end
      u = due_q.pop_front();
      if (u.a_updated !== a_upd || u.last_result !== last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: a_updated exp %h got %h, last exp %b got %b",
                     u.a_updated, a_upd, u.last_result, last);
      end
   endfunction

   function int pending();
      return due_q.size();
   endfunction
endclass

module tb;
   import hfr1_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_a_value;
   logic [15:0] req_x_value;
   logic [15:0] req_y_value;
   logic        req_last_element;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_a_updated;
   logic        rsp_last_result;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_alpha;

   rank1_scoreboard rank1_sb;
   int              idle_pct;
   int              stall_pct;
   int              hold_left;
   int              cycles;
   logic [15:0]     alphas [10] = '{16'h0000, 16'h8000, 16'h3C00, 16'h7BFF, 16'h0001,
                                    16'hFFFF, 16'h7C00, 16'hBC00, 16'h3800, 16'hC500};

   half_float_rank1_update_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_a_value      (req_a_value),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_a_updated    (rsp_a_updated),
      .rsp_last_result  (rsp_last_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_alpha        (csr_alpha)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Run limit: a hung handshake ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response side: check every beat at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         rank1_sb.check_response(rsp_a_updated, rsp_last_result);
   end

   // Drive stall at the falling edge; a long hold-off overrides the random stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Pick an operand: mostly well-scaled values, some raw patterns and specials.
   function automatic logic [15:0] pick_half();
      logic [15:0] specials [10] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                     16'h7C01, 16'h0001, 16'h03FF, 16'h0400, 16'h7BFF};
      int          sel;
      sel = $urandom_range(99);
      if (sel < 25) return 16'($urandom);
      if (sel < 80) return {1'($urandom), 5'($urandom_range(20, 9)), 10'($urandom)};
      return specials[$urandom_range(9)];
   endfunction

   // Offer one request beat, idling first at random; hold it until accepted.
   task automatic send_item(logic [15:0] a, logic [15:0] x, logic [15:0] y, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_a_value      <= a;
      req_x_value      <= x;
      req_y_value      <= y;
      req_last_element <= last;
      do @(posedge clock); while (req_stall);
      rank1_sb.note_request(a, x, y, last);
      @(negedge clock);
   endtask

   // Wait until every update is back, let the pipeline drain, then write alpha.
   task automatic write_alpha(logic [15:0] value);
      req_valid <= 1'b0;
      while (rank1_sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_alpha <= value;
      do @(posedge clock); while (!csr_ready);
      rank1_sb.alpha = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_items();
      send_item(16'h0000, 16'h3C00, 16'h3C00, 1'b0);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(16'h7E00, 16'h7C00, 16'h8000, 1'b0); // zero y passes a through
      send_item(16'h3C00, 16'h7C00, 16'h3C00, 1'b0);
      send_item(16'h7C00, 16'h7C00, 16'hBC00, 1'b0); // inf minus inf
      send_item(16'h3C00, 16'h7C00, 16'h0000, 1'b1);
      send_item(16'h3C00, 16'h0000, 16'h7C00, 1'b0); // inf times zero
      send_item(16'h7BFF, 16'h7BFF, 16'h7BFF, 1'b0); // overflow
      send_item(16'h0001, 16'h0001, 16'h0001, 1'b0); // underflow
      send_item(16'h3C00, 16'h3C00, 16'hBC00, 1'b0); // exact cancel gives +0
      send_item(16'h8000, 16'h8000, 16'h3C00, 1'b1); // signed zeros
      send_item(16'h03FF, 16'h0400, 16'h3C00, 1'b0);
      send_item(16'h7C01, 16'h3C00, 16'h3C00, 1'b0);
      send_item(16'h3C00, 16'h7E00, 16'h3C00, 1'b0);
      send_item(16'h3C00, 16'h3C00, 16'h7FFF, 1'b0);
      send_item(16'h1234, 16'h5678, 16'h0001, 1'b1);
   endtask

   initial begin
      rank1_sb         = new();
      cycles           = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      hold_left        = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_a_value      = 16'd0;
      req_x_value      = 16'd0;
      req_y_value      = 16'd0;
      req_last_element = 1'b0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_alpha        = 16'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats at reset alpha and at unit alpha.
      directed_items();
      write_alpha(16'h3C00);
      directed_items();

      // Random phases: step through alpha settings and idling and stalling modes.
      for (int ph = 0; ph < 8; ph++) begin
         write_alpha((ph < 6) ? alphas[ph + 4] : 16'($urandom));
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 63; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Hold the receiver off for a long stretch while the sender keeps offering.
            if (ph == 0 && i == 50) begin
               req_valid <= 1'b0;
               @(posedge clock);
               hold_left = 300;
               @(negedge clock);
            end
            // Pause the sender until every update is back.
            if (ph == 2 && i == 100) begin
               req_valid <= 1'b0;
               while (rank1_sb.pending() != 0) @(posedge clock);
               @(negedge clock);
            end
            send_item(pick_half(), pick_half(),
                      ($urandom_range(9) == 0) ? 16'h8000 : pick_half(), 1'($urandom));
         end
      end
      write_alpha(16'h0000);
      send_item(16'h7E00, 16'h7C00, 16'h3C00, 1'b1);
      req_valid <= 1'b0;

      while (rank1_sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (rank1_sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
